// ----- hw/rtl/sfpf_pkg.sv -----
package sfpf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned PosW  = 6;

	localparam logic [ByteW-1:0] FirstSyncRst  = 8'h81;
	localparam logic [ByteW-1:0] SecondSyncRst = 8'hA1;

	localparam logic CfgIdxFirstSync  = 1'b0;
	localparam logic CfgIdxSecondSync = 1'b1;

	typedef enum logic [5:0] {
		ST_HUNT  = 6'b000001,
		ST_SYNC2 = 6'b000010,
		ST_DATA  = 6'b000100,
		ST_CK0   = 6'b001000,
		ST_CK1   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic clear_sums;
		logic gather;
		logic clr_rd;
		logic rd_issue;
	} dp_cmd_t;

	typedef struct packed {
		logic sync1_hit;
		logic sync2_hit;
		logic ck0_hit;
		logic ck1_hit;
		logic data_last;
		logic rd_last;
		logic slot_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/sfpf_ram.sv -----
module sfpf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/sfpf_ctrl.sv -----
module sfpf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfpf_pkg::dp_status_t status,
	output sfpf_pkg::dp_cmd_t    cmd
);

	sfpf_pkg::state_t state_q, state_d;
	logic             fire;

	assign in_ready = (state_q != sfpf_pkg::ST_EMIT);
	assign fire     = in_valid && in_ready;

	always_comb begin
		state_d        = state_q;
		cmd.clear_sums = 1'b0;
		cmd.gather     = 1'b0;
		cmd.clr_rd     = 1'b0;
		cmd.rd_issue   = 1'b0;
		unique case (state_q)
			sfpf_pkg::ST_HUNT: begin
				if (fire && status.sync1_hit) begin
					state_d = sfpf_pkg::ST_SYNC2;
				end
			end
			sfpf_pkg::ST_SYNC2: begin
				if (fire) begin
					cmd.clear_sums = 1'b1;
					state_d = status.sync2_hit ? sfpf_pkg::ST_DATA : sfpf_pkg::ST_HUNT;
				end
			end
			sfpf_pkg::ST_DATA: begin
				if (fire) begin
					cmd.gather = 1'b1;
					if (status.data_last) begin
						state_d = sfpf_pkg::ST_CK0;
					end
				end
			end
			sfpf_pkg::ST_CK0: begin
				if (fire) begin
					state_d = status.ck0_hit ? sfpf_pkg::ST_CK1 : sfpf_pkg::ST_HUNT;
				end
			end
			sfpf_pkg::ST_CK1: begin
				if (fire) begin
					cmd.clr_rd = 1'b1;
					state_d = status.ck1_hit ? sfpf_pkg::ST_EMIT : sfpf_pkg::ST_HUNT;
				end
			end
			sfpf_pkg::ST_EMIT: begin
				// one stored byte read per free output slot
				if (status.slot_free) begin
					cmd.rd_issue = 1'b1;
					if (status.rd_last) begin
						state_d = sfpf_pkg::ST_HUNT;
					end
				end
			end
			default: begin
				state_d = sfpf_pkg::ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfpf_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/sfpf_dp.sv -----
module sfpf_dp #(
	parameter int unsigned PAYLOAD_LEN = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sfpf_pkg::ByteW-1:0]    cfg_data,
	input  logic [sfpf_pkg::ByteW-1:0]    rx_byte,
	input  sfpf_pkg::dp_cmd_t             cmd,
	output sfpf_pkg::dp_status_t          status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sfpf_pkg::ByteW-1:0]    payload_byte,
	output logic [sfpf_pkg::PosW-1:0]     byte_position,
	output logic                          last_of_frame
);

	localparam int unsigned AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam logic [AW-1:0] LastIdx = AW'(PAYLOAD_LEN - 1);

	logic [sfpf_pkg::ByteW-1:0] first_sync_q, second_sync_q;
	logic [sfpf_pkg::ByteW-1:0] sum_low_q, sum_high_q, sum_low_nx;
	logic [AW-1:0]              wr_idx_q, rd_idx_q;
	logic                       out_valid_q, last_q;
	logic [sfpf_pkg::PosW-1:0]  pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= sfpf_pkg::FirstSyncRst;
			second_sync_q <= sfpf_pkg::SecondSyncRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfpf_pkg::CfgIdxFirstSync:  first_sync_q  <= cfg_data;
				sfpf_pkg::CfgIdxSecondSync: second_sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sum_low_nx = sum_low_q + rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= '0;
			sum_high_q <= '0;
			wr_idx_q   <= '0;
		end else if (cmd.clear_sums) begin
			sum_low_q  <= '0;
			sum_high_q <= '0;
			wr_idx_q   <= '0;
		end else if (cmd.gather) begin
			sum_low_q  <= sum_low_nx;
			sum_high_q <= sum_high_q + sum_low_nx;
			wr_idx_q   <= wr_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.clr_rd) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_issue) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	sfpf_ram #(
		.WIDTH(sfpf_pkg::ByteW),
		.DEPTH(PAYLOAD_LEN)
	) u_store (
		.clk   (clk),
		.we    (cmd.gather),
		.waddr (wr_idx_q),
		.wdata (rx_byte),
		.re    (cmd.rd_issue),
		.raddr (rd_idx_q),
		.rdata (payload_byte)
	);

	// read data lands in the RAM output register alongside these
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			pos_q  <= sfpf_pkg::PosW'(rd_idx_q);
			last_q <= (rd_idx_q == LastIdx);
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_position = pos_q;
	assign last_of_frame = last_q;

	assign status.sync1_hit = (rx_byte == first_sync_q);
	assign status.sync2_hit = (rx_byte == second_sync_q);
	assign status.ck0_hit   = (rx_byte == sum_low_q);
	assign status.ck1_hit   = (rx_byte == sum_high_q);
	assign status.data_last = (wr_idx_q == LastIdx);
	assign status.rd_last   = (rd_idx_q == LastIdx);
	assign status.slot_free = !out_valid_q || out_ready;

endmodule

// ----- hw/rtl/sync_frame_parser_fletcher.sv -----
// Sync-byte frame parser with an 8-bit Fletcher check.
// Input channel (in_valid/in_ready, rx_byte): one received byte per request,
// taken while the parser hunts, checks sync, gathers payload or checks the
// two sum bytes.
// Output channel (out_valid/out_ready): payload_byte, byte_position and
// last_of_frame for each byte of a frame whose checksum matched.
// After the second check byte matches, the stored payload is read out of the
// RAM one byte per cycle while the receiver does not stall, the rate set by
// the single RAM read port; each read lands in the output register. in_ready
// is low during this read-out; it rises again once the last byte has been
// read, even while that byte still waits. A stall on out_ready holds the
// output register and pauses the read-out. Failing frames produce nothing.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 first sync value,
// index 1 second sync value; write only while idle.
// Reset: sync values 0x81 / 0xA1, parser hunting, sums zero, output empty.
module sync_frame_parser_fletcher #(
	parameter int unsigned PAYLOAD_LEN = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [sfpf_pkg::ByteW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sfpf_pkg::ByteW-1:0] rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sfpf_pkg::ByteW-1:0] payload_byte,
	output logic [sfpf_pkg::PosW-1:0]  byte_position,
	output logic                       last_of_frame
);

	sfpf_pkg::dp_cmd_t    cmd;
	sfpf_pkg::dp_status_t status;

	sfpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sfpf_dp #(
		.PAYLOAD_LEN(PAYLOAD_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.byte_position (byte_position),
		.last_of_frame (last_of_frame)
	);

endmodule

// ----- sim/sync_frame_parser_fletcher_tb.sv -----
`timescale 1ns / 100ps

module sync_frame_parser_fletcher_tb;

	localparam int unsigned BYTE_W    = sfpf_pkg::ByteW;
	localparam int unsigned POS_W     = sfpf_pkg::PosW;
	localparam int unsigned PLEN      = 32;
	localparam int unsigned SETTLE    = 40;
	localparam int unsigned HOLD_LEN  = 300;
	localparam int unsigned CYC_LIMIT = 200000;
	localparam int unsigned PHASE_MIN = 20;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_DATA,
		PH_CK0,
		PH_CK1
	} phase_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_SYNC2,
		FR_BAD_CK0,
		FR_BAD_CK1
	} frame_t;

	typedef enum int {
		FILL_RAND,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
		logic              last;
	} beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = sfpf_pkg::CfgIdxFirstSync;
	logic [BYTE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] payload_byte;
	logic [POS_W-1:0]  byte_position;
	logic              last_of_frame;

	sync_frame_parser_fletcher #(
		.PAYLOAD_LEN(PLEN)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.byte_position(byte_position),
		.last_of_frame(last_of_frame)
	);

	always #4 clk = ~clk;

	// parser copy
	logic [BYTE_W-1:0] sync1_cfg = sfpf_pkg::FirstSyncRst;
	logic [BYTE_W-1:0] sync2_cfg = sfpf_pkg::SecondSyncRst;
	phase_t            phase = PH_HUNT;
	int unsigned       gathered = 0;
	logic [BYTE_W-1:0] frame_store [PLEN];
	logic [BYTE_W-1:0] sum_lo = '0;
	logic [BYTE_W-1:0] sum_hi = '0;

	beat_t             payload_q [$];
	logic [BYTE_W-1:0] rx_q [$];
	int unsigned       pushed_n = 0;
	int unsigned       accepted_n = 0;
	int unsigned       noise_n = 0;
	int unsigned       err_n = 0;
	int unsigned       cycles = 0;
	bit                rx_taken = 1'b0;
	bit                steady = 1'b0;
	bit                hold_req = 1'b0;
	bit                hold_seen = 1'b0;
	int unsigned       hold_left = 0;
	beat_t             got_beat;
	beat_t             exp_beat;

	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_n++;
	endtask

	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		beat_t bt;
		case (phase)
			PH_SYNC2: begin
				phase = (b == sync2_cfg) ? PH_DATA : PH_HUNT;
				sum_lo = '0;
				sum_hi = '0;
				gathered = 0;
			end
			PH_DATA: begin
				frame_store[gathered] = b;
				gathered++;
				sum_lo = sum_lo + b;
				sum_hi = sum_hi + sum_lo;
				if (gathered >= PLEN)
					phase = PH_CK0;
			end
			PH_CK0: begin
				phase = (b == sum_lo) ? PH_CK1 : PH_HUNT;
			end
			PH_CK1: begin
				// second check byte closes the frame either way
				phase = PH_HUNT;
				if (b == sum_hi) begin
					for (int k = 0; k < PLEN; k++) begin
						bt.data = frame_store[k];
						bt.pos  = POS_W'(k);
						bt.last = (k == PLEN - 1);
						payload_q.push_back(bt);
					end
				end
			end
			default: begin
				if (b == sync1_cfg) begin
					phase = PH_SYNC2;
					gathered = 0;
				end else begin
					phase = PH_HUNT;
				end
			end
		endcase
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || rx_taken)) begin
			if (rx_q.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
				in_valid <= 1'b1;
				rx_byte  <= rx_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with its own long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 31);
		end
	end

	// monitor: predict on accepted bytes, then check accepted results
	always @(posedge clk) begin
		rx_taken = in_valid && in_ready;
		if (arst_n) begin
			if (rx_taken) begin
				accepted_n++;
				parse_byte(rx_byte);
			end
			if (out_valid && out_ready) begin
				got_beat = {payload_byte, byte_position, last_of_frame};
				if (payload_q.size() == 0) begin
					report_err($sformatf("unexpected result byte=%02h pos=%0d last=%b",
						payload_byte, byte_position, last_of_frame));
				end else begin
					exp_beat = payload_q.pop_front();
					if (got_beat !== exp_beat)
						report_err($sformatf("got byte=%02h pos=%0d last=%b, want %02h %0d %b",
							got_beat.data, got_beat.pos, got_beat.last,
							exp_beat.data, exp_beat.pos, exp_beat.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_rx(input logic [BYTE_W-1:0] b);
		rx_q.push_back(b);
		pushed_n++;
	endtask

	task automatic push_noise(input int n);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			b = BYTE_W'($urandom_range(255));
			if (b == sync1_cfg)
				b = b ^ 8'h01;
			push_rx(b);
			noise_n++;
		end
	endtask

	function automatic logic [BYTE_W-1:0] pick_bad(input logic [BYTE_W-1:0] right,
		input bit as_sync);
		if (as_sync && sync1_cfg != right)
			return sync1_cfg;
		return right ^ BYTE_W'($urandom_range(1, 255));
	endfunction

	// one frame as the sender sees it; a bad byte may mimic the first sync
	task automatic push_frame(input frame_t kind, input fill_t fill, input bit as_sync);
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		logic [BYTE_W-1:0] b;
		lo = '0;
		hi = '0;
		push_rx(sync1_cfg);
		if (kind == FR_BAD_SYNC2) begin
			push_rx(pick_bad(sync2_cfg, as_sync));
			return;
		end
		push_rx(sync2_cfg);
		for (int i = 0; i < PLEN; i++) begin
			case (fill)
				FILL_ZERO: b = '0;
				FILL_ONES: b = '1;
				default:   b = BYTE_W'($urandom_range(255));
			endcase
			push_rx(b);
			lo = lo + b;
			hi = hi + lo;
		end
		if (kind == FR_BAD_CK0) begin
			push_rx(pick_bad(lo, as_sync));
			return;
		end
		push_rx(lo);
		push_rx((kind == FR_BAD_CK1) ? pick_bad(hi, as_sync) : hi);
	endtask

	task automatic cfg_write(input logic idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == sfpf_pkg::CfgIdxFirstSync)
			sync1_cfg = val;
		else
			sync2_cfg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every byte taken and every result seen, then let the block settle
	task automatic drain();
		while (accepted_n != pushed_n || payload_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic random_frames(input int unsigned target);
		int unsigned start;
		int unsigned r;
		fill_t       f;
		start = pushed_n - noise_n;
		while (pushed_n - noise_n - start < target) begin
			r = $urandom_range(99);
			f = ($urandom_range(9) == 0) ? FILL_ZERO :
				($urandom_range(9) == 0) ? FILL_ONES : FILL_RAND;
			if (r < 45)
				push_frame(FR_GOOD, f, 1'b0);
			else if (r < 60)
				push_frame(FR_BAD_SYNC2, f, 1'($urandom_range(1)));
			else if (r < 75)
				push_frame(FR_BAD_CK0, f, 1'($urandom_range(1)));
			else if (r < 90)
				push_frame(FR_BAD_CK1, f, 1'($urandom_range(1)));
			else
				push_noise($urandom_range(1, 4));
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] s;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset sync values; directed cases first
		push_rx(8'h00);
		push_rx(8'hFF);
		// second byte equal to first sync is a bad second sync, not a new start
		push_rx(sync1_cfg);
		push_rx(sync1_cfg);
		push_rx(sync2_cfg);
		push_frame(FR_GOOD, FILL_ONES, 1'b0);
		push_frame(FR_BAD_CK1, FILL_ZERO, 1'b1);
		push_frame(FR_BAD_CK0, FILL_RAND, 1'b1);
		push_rx(sync2_cfg);
		push_frame(FR_GOOD, FILL_ZERO, 1'b0);
		random_frames(PHASE_MIN);
		drain();

		cfg_write(sfpf_pkg::CfgIdxFirstSync, 8'h00);
		cfg_write(sfpf_pkg::CfgIdxSecondSync, 8'hFF);
		random_frames(PHASE_MIN);
		drain();

		// long receiver stall while the sender keeps offering
		cfg_write(sfpf_pkg::CfgIdxFirstSync, 8'hFF);
		cfg_write(sfpf_pkg::CfgIdxSecondSync, 8'h00);
		push_frame(FR_GOOD, FILL_RAND, 1'b0);
		random_frames(PHASE_MIN);
		hold_req = ~hold_req;
		drain();

		steady = 1'b1;
		cfg_write(sfpf_pkg::CfgIdxFirstSync, BYTE_W'($urandom_range(255)));
		cfg_write(sfpf_pkg::CfgIdxSecondSync, BYTE_W'($urandom_range(255)));
		random_frames(PHASE_MIN);
		drain();
		steady = 1'b0;

		// both sync values equal
		s = BYTE_W'($urandom_range(255));
		cfg_write(sfpf_pkg::CfgIdxFirstSync, s);
		cfg_write(sfpf_pkg::CfgIdxSecondSync, s);
		random_frames(PHASE_MIN);
		drain();

		if (err_n == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/sfpf_pkg.sv
hw/rtl/sfpf_ram.sv
hw/rtl/sfpf_ctrl.sv
hw/rtl/sfpf_dp.sv
hw/rtl/sync_frame_parser_fletcher.sv
sim/sync_frame_parser_fletcher_tb.sv
